// ===== rtl/core/rep_pkg.sv =====
// Shared types and constants for the rotary encoder position tracker.
`timescale 1ns / 1ps
`default_nettype none

package rep_pkg;

  localparam int POSITION_WIDTH = 16;
  localparam int LOAD_WIDTH     = 16;
  localparam int TICK_WIDTH     = 8;

  localparam logic [TICK_WIDTH-1:0] LOCKOUT_RESET = TICK_WIDTH'(2);
  localparam logic [TICK_WIDTH-1:0] TICK_MAX      = {TICK_WIDTH{1'b1}};
  localparam logic [TICK_WIDTH-1:0] TICK_ONE      = TICK_WIDTH'(1);

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_LOAD   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]                   command;
    logic                         clk_level;
    logic                         dt_level;
    logic signed [LOAD_WIDTH-1:0] load_value;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/rep_in_reg.sv =====
// Input register stage of the rotary encoder position tracker.
`timescale 1ns / 1ps
`default_nettype none

module rep_in_reg
  import rep_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  // take a new item whenever the held one leaves this cycle or none is held
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rep_core.sv =====
// Decoder state, command execution and result register.
`timescale 1ns / 1ps
`default_nettype none

module rep_core
  import rep_pkg::*;
(
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [TICK_WIDTH-1:0]           cfg_wdata,
  input  wire logic                            item_valid,
  input  wire item_t                           item,
  output logic                                 advance,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [POSITION_WIDTH-1:0]     out_position,
  output logic                                 out_moved
);

  logic [TICK_WIDTH-1:0]     lockout_r;
  logic                      prev_clk_r, prev_clk_nxt;
  logic                      half_r, half_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic                      moved_r, moved_nxt;
  logic [TICK_WIDTH-1:0]     ticks_r, ticks_nxt;
  logic                      moved_res;
  logic                      change;
  logic                      fire;
  logic                      out_valid_r;
  logic [POSITION_WIDTH-1:0] out_pos_r;
  logic                      out_moved_r;

  assign advance      = !out_valid_r || out_ready;
  assign fire         = item_valid && advance;
  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_moved    = out_moved_r;

  assign change = (ticks_r >= lockout_r) && (item.clk_level != prev_clk_r);

  always_comb begin
    prev_clk_nxt = prev_clk_r;
    half_nxt     = half_r;
    pos_nxt      = pos_r;
    moved_nxt    = moved_r;
    ticks_nxt    = ticks_r;
    moved_res    = moved_r;
    unique case (item.command)
      CMD_SAMPLE: begin
        if (change) begin
          // change with half_r set completes a detent: move up when CLK and DT differ
          if (half_r) begin
            if (item.clk_level != item.dt_level) begin
              pos_nxt = pos_r + POSITION_WIDTH'(1);
            end else begin
              pos_nxt = pos_r - POSITION_WIDTH'(1);
            end
            moved_nxt = 1'b1;
          end
          half_nxt     = !half_r;
          prev_clk_nxt = item.clk_level;
          ticks_nxt    = TICK_ONE;
        end else if (ticks_r != TICK_MAX) begin
          ticks_nxt = ticks_r + TICK_ONE;
        end
        moved_res = moved_nxt;
      end
      CMD_READ: begin
        moved_nxt = 1'b0;
      end
      CMD_LOAD: begin
        pos_nxt   = POSITION_WIDTH'(item.load_value);
        moved_nxt = 1'b0;
        moved_res = 1'b0;
      end
      default: begin
        moved_res = moved_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r   <= LOCKOUT_RESET;
      prev_clk_r  <= 1'b0;
      half_r      <= 1'b0;
      pos_r       <= '0;
      moved_r     <= 1'b0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        lockout_r <= cfg_wdata;
      end
      if (fire) begin
        prev_clk_r <= prev_clk_nxt;
        half_r     <= half_nxt;
        pos_r      <= pos_nxt;
        moved_r    <= moved_nxt;
        ticks_r    <= ticks_nxt;
      end
      if (advance) begin
        out_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pos_r   <= pos_nxt;
      out_moved_r <= moved_res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rotary_encoder_position_tracker.sv =====
// Top level of the rotary encoder position tracker.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | command, clk_level, dt_level, load_value
//   out_    | output    | out_valid / out_ready | position, moved
//   cfg_    | input     | cfg_we (no wait)      | cfg_wdata = lockout_ticks
//
// One item per cycle sustained unless out_ready stalls the result; each item passes
// from acceptance through the input register, then through the decoder logic into
// the result register, which is updated together with the decoder state.
// Reset (rst_n low, synchronous) clears position, flags, tick count and sets the
// lockout to two ticks. A stalled result holds in the result register; the input
// register still takes an item when the result leaves in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_position_tracker
  import rep_pkg::*;
(
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [TICK_WIDTH-1:0]              cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         in_command,
  input  wire logic                               in_clk_level,
  input  wire logic                               in_dt_level,
  input  wire logic signed [LOAD_WIDTH-1:0]       in_load_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [POSITION_WIDTH-1:0]        out_position,
  output logic                                    out_moved
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;

  assign in_item.command    = in_command;
  assign in_item.clk_level  = in_clk_level;
  assign in_item.dt_level   = in_dt_level;
  assign in_item.load_value = in_load_value;

  rep_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rep_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item         (item),
    .advance      (advance),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_position (out_position),
    .out_moved    (out_moved)
  );

endmodule

`default_nettype wire
